// ----- hdl/pit_pkg.sv -----
// Package for the phased interval timer: types, command and phase codes,
// configuration defaults and the minutes-to-seconds helper.
// No dependencies; every other file in hdl/ uses it.
`timescale 1ns / 1ps

package pit_pkg;

  // Field widths.
  localparam int unsigned CmdW     = 3;
  localparam int unsigned PhaseW   = 2;
  localparam int unsigned MinW     = 11;
  localparam int unsigned SecW     = 17;
  localparam int unsigned SessionW = 16;
  localparam int unsigned CycleW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned EventW   = 2;
  localparam int unsigned StepCntW = $clog2(SessionW);

  // Limits and defaults.
  localparam logic [MinW-1:0]     MaxStartMinutes  = MinW'(1440);
  localparam logic [MinW-1:0]     LengthCapMinutes = MinW'(1440);
  localparam logic [SessionW-1:0] SessionMax       = '1;
  localparam logic [MinW-1:0]     FocusDefault     = MinW'(25);
  localparam logic [MinW-1:0]     ShortDefault     = MinW'(5);
  localparam logic [MinW-1:0]     LongDefault      = MinW'(15);
  localparam logic [CycleW-1:0]   CycleDefault     = CycleW'(4);

  // Command codes.
  localparam logic [CmdW-1:0] CmdTick   = 3'd0;
  localparam logic [CmdW-1:0] CmdStart  = 3'd1;
  localparam logic [CmdW-1:0] CmdPause  = 3'd2;
  localparam logic [CmdW-1:0] CmdResume = 3'd3;
  localparam logic [CmdW-1:0] CmdStop   = 3'd4;
  localparam logic [CmdW-1:0] CmdSkip   = 3'd5;

  // Phase codes; the fourth code is invalid for start.
  localparam logic [PhaseW-1:0] PhFocus   = 2'd0;
  localparam logic [PhaseW-1:0] PhShort   = 2'd1;
  localparam logic [PhaseW-1:0] PhLong    = 2'd2;
  localparam logic [PhaseW-1:0] PhInvalid = 2'd3;

  // Phase event codes.
  localparam logic [EventW-1:0] EvNone  = 2'd0;
  localparam logic [EventW-1:0] EvFocus = 2'd1;
  localparam logic [EventW-1:0] EvBreak = 2'd2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFocus = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgShort = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgLong  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgCycle = 2'd3;

  typedef enum logic [2:0] {
    StIdle,
    StEval,
    StMod,
    StEnter,
    StDone
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch_in;
    logic eval;
    logic mod_step;
    logic enter;
    logic load_out;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic complete;
    logic focus;
  } dp_status_t;

  // Zero acts as one minute, anything above the cap acts as the cap.
  function automatic logic [SecW-1:0] minutes_to_seconds(input logic [MinW-1:0] m);
    logic [MinW-1:0] mm;
    logic [SecW-1:0] wide;
    mm = m;
    if (mm == '0) begin
      mm = MinW'(1);
    end else if (mm > LengthCapMinutes) begin
      mm = LengthCapMinutes;
    end
    wide = SecW'(mm);
    return (wide << 6) - (wide << 2);
  endfunction

endpackage

// ----- hdl/pit_if.sv -----
// Channel interfaces of the phased interval timer: command input, result
// output and configuration write. Depends on pit_pkg for field widths.
`timescale 1ns / 1ps

interface pit_in_if;
  logic                       valid;
  logic                       ready;
  logic [pit_pkg::CmdW-1:0]   cmd;
  logic [pit_pkg::PhaseW-1:0] start_phase;
  logic [pit_pkg::MinW-1:0]   start_minutes;

  modport source (output valid, cmd, start_phase, start_minutes, input ready);
  modport sink (input valid, cmd, start_phase, start_minutes, output ready);
endinterface

interface pit_out_if;
  logic                         valid;
  logic                         ready;
  logic                         accepted;
  logic                         active_flag;
  logic                         running_flag;
  logic [pit_pkg::SecW-1:0]     remaining_seconds;
  logic [pit_pkg::SecW-1:0]     phase_seconds;
  logic [pit_pkg::SessionW-1:0] sessions_done;
  logic [pit_pkg::PhaseW-1:0]   current_phase;
  logic [pit_pkg::EventW-1:0]   phase_event;

  modport source (output valid, accepted, active_flag, running_flag, remaining_seconds,
                  phase_seconds, sessions_done, current_phase, phase_event,
                  input ready);
  modport sink (input valid, accepted, active_flag, running_flag, remaining_seconds,
                phase_seconds, sessions_done, current_phase, phase_event,
                output ready);
endinterface

interface pit_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [pit_pkg::CfgIdxW-1:0] index;
  logic [pit_pkg::MinW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/pit_ctrl.sv -----
// Controller state machine of the phased interval timer: sequences each
// request through evaluation, the remainder steps and phase entry.
// Depends on pit_pkg.
`timescale 1ns / 1ps

module pit_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  pit_pkg::dp_status_t status_i,
  output pit_pkg::dp_cmd_t    cmd_o
);

  localparam logic [pit_pkg::StepCntW-1:0] LastStep = pit_pkg::StepCntW'(pit_pkg::SessionW - 1);

  pit_pkg::state_e state_q, state_d;
  logic [pit_pkg::StepCntW-1:0] step_q, step_d;
  logic out_valid_q, out_valid_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pit_pkg::StIdle: begin
        if (in_valid_i) state_d = pit_pkg::StEval;
      end
      pit_pkg::StEval: begin
        if (!status_i.complete) begin
          state_d = pit_pkg::StDone;
        end else if (status_i.focus) begin
          state_d = pit_pkg::StMod;
        end else begin
          state_d = pit_pkg::StEnter;
        end
      end
      pit_pkg::StMod: begin
        if (step_q == LastStep) state_d = pit_pkg::StEnter;
      end
      pit_pkg::StEnter: begin
        state_d = pit_pkg::StDone;
      end
      pit_pkg::StDone: begin
        if (!out_valid_q || out_ready_i) state_d = pit_pkg::StIdle;
      end
      default: begin
        state_d = pit_pkg::StIdle;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pit_pkg::StIdle: begin
        in_ready_o     = 1'b1;
        cmd_o.latch_in = in_valid_i;
      end
      pit_pkg::StEval: begin
        cmd_o.eval = 1'b1;
      end
      pit_pkg::StMod: begin
        cmd_o.mod_step = 1'b1;
      end
      pit_pkg::StEnter: begin
        cmd_o.enter = 1'b1;
      end
      pit_pkg::StDone: begin
        cmd_o.load_out = !out_valid_q || out_ready_i;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

  always_comb begin
    step_d = step_q;
    if (state_q == pit_pkg::StEval) begin
      step_d = '0;
    end else if (state_q == pit_pkg::StMod) begin
      step_d = step_q + pit_pkg::StepCntW'(1);
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= pit_pkg::StIdle;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_load_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |=> out_valid_q)
    else $error("result load did not raise out_valid");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_out |-> (!out_valid_q || out_ready_i))
    else $error("pending result overwritten");

  a_mod_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == pit_pkg::StMod && step_q == LastStep) |=> state_q == pit_pkg::StEnter)
    else $error("remainder sequence did not end after its last step");

  a_eval_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == pit_pkg::StEval |=> state_q != pit_pkg::StEval)
    else $error("evaluation held for more than one cycle");
`endif

endmodule

// ----- hdl/pit_datapath.sv -----
// Datapath of the phased interval timer: configuration registers, timer
// state, the bit-serial session remainder and the result register.
// Depends on pit_pkg; driven by pit_ctrl through dp_cmd_t.
`timescale 1ns / 1ps

module pit_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pit_pkg::dp_cmd_t              cmd_i,
  output pit_pkg::dp_status_t           status_o,
  input  logic                          cfg_we_i,
  input  logic [pit_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [pit_pkg::MinW-1:0]      cfg_data_i,
  input  logic [pit_pkg::CmdW-1:0]      cmd_code_i,
  input  logic [pit_pkg::PhaseW-1:0]    start_phase_i,
  input  logic [pit_pkg::MinW-1:0]      start_minutes_i,
  output logic                          accepted_o,
  output logic                          active_flag_o,
  output logic                          running_flag_o,
  output logic [pit_pkg::SecW-1:0]      remaining_seconds_o,
  output logic [pit_pkg::SecW-1:0]      phase_seconds_o,
  output logic [pit_pkg::SessionW-1:0]  sessions_done_o,
  output logic [pit_pkg::PhaseW-1:0]    current_phase_o,
  output logic [pit_pkg::EventW-1:0]    phase_event_o
);

  // Configuration.
  logic [pit_pkg::MinW-1:0]   focus_min_q, short_min_q, long_min_q;
  logic [pit_pkg::CycleW-1:0] cycle_q;

  // Timer state.
  logic                         active_q, active_d;
  logic                         running_q, running_d;
  logic [pit_pkg::SecW-1:0]     remain_q, remain_d;
  logic [pit_pkg::SecW-1:0]     length_q, length_d;
  logic [pit_pkg::SessionW-1:0] session_q, session_d;
  logic [pit_pkg::PhaseW-1:0]   phase_q, phase_d;
  logic                         acc_q, acc_d;
  logic [pit_pkg::EventW-1:0]   event_q, event_d;

  // Latched request.
  logic [pit_pkg::CmdW-1:0]   code_q;
  logic [pit_pkg::PhaseW-1:0] sph_q;
  logic [pit_pkg::MinW-1:0]   smin_q;

  // Remainder unit: dividend shifts out MSB first, one bit per step.
  logic [pit_pkg::SessionW-1:0] div_q, div_d;
  logic [pit_pkg::CycleW:0]     rem_q, rem_d;
  logic [pit_pkg::CycleW:0]     rem_shift, divisor;

  // Result register.
  logic                         res_acc_q, res_active_q, res_running_q;
  logic [pit_pkg::SecW-1:0]     res_remain_q, res_length_q;
  logic [pit_pkg::SessionW-1:0] res_session_q;
  logic [pit_pkg::PhaseW-1:0]   res_phase_q;
  logic [pit_pkg::EventW-1:0]   res_event_q;

  logic [pit_pkg::SecW-1:0]     remain_dec;
  logic [pit_pkg::SessionW-1:0] session_inc;
  logic [pit_pkg::MinW-1:0]     start_cfg_min, start_min;
  logic [pit_pkg::PhaseW-1:0]   next_phase;
  logic [pit_pkg::MinW-1:0]     next_cfg_min;
  logic                         start_ok;

  function automatic logic [pit_pkg::MinW-1:0] cfg_minutes(
    input logic [pit_pkg::PhaseW-1:0] ph,
    input logic [pit_pkg::MinW-1:0]   f,
    input logic [pit_pkg::MinW-1:0]   s,
    input logic [pit_pkg::MinW-1:0]   l
  );
    logic [pit_pkg::MinW-1:0] m;
    m = f;
    if (ph == pit_pkg::PhShort) begin
      m = s;
    end else if (ph == pit_pkg::PhLong) begin
      m = l;
    end
    return m;
  endfunction

  always_comb begin
    remain_dec = remain_q;
    if (running_q && remain_q != '0) remain_dec = remain_q - pit_pkg::SecW'(1);
  end

  assign session_inc = (session_q != pit_pkg::SessionMax) ?
                       session_q + pit_pkg::SessionW'(1) : session_q;

  assign start_ok = !active_q && (sph_q != pit_pkg::PhInvalid) &&
                    (smin_q <= pit_pkg::MaxStartMinutes);
  assign start_cfg_min = cfg_minutes(sph_q, focus_min_q, short_min_q, long_min_q);
  assign start_min     = (smin_q != '0) ? smin_q : start_cfg_min;

  assign next_phase   = (phase_q != pit_pkg::PhFocus) ? pit_pkg::PhFocus :
                        ((rem_q == '0) ? pit_pkg::PhLong : pit_pkg::PhShort);
  assign next_cfg_min = cfg_minutes(next_phase, focus_min_q, short_min_q, long_min_q);

  always_comb begin
    status_o.focus    = (phase_q == pit_pkg::PhFocus);
    status_o.complete = 1'b0;
    if (code_q == pit_pkg::CmdTick) begin
      status_o.complete = active_q && running_q && (remain_dec == '0);
    end else if (code_q == pit_pkg::CmdSkip) begin
      status_o.complete = active_q;
    end
  end

  assign divisor   = (cycle_q == '0) ? (pit_pkg::CycleW+1)'(1) : {1'b0, cycle_q};
  assign rem_shift = {rem_q[pit_pkg::CycleW-1:0], div_q[pit_pkg::SessionW-1]};

  always_comb begin
    active_d  = active_q;
    running_d = running_q;
    remain_d  = remain_q;
    length_d  = length_q;
    session_d = session_q;
    phase_d   = phase_q;
    acc_d     = acc_q;
    event_d   = event_q;
    div_d     = div_q;
    rem_d     = rem_q;

    if (cmd_i.eval) begin
      acc_d   = 1'b0;
      event_d = pit_pkg::EvNone;
      case (code_q)
        pit_pkg::CmdTick: begin
          if (active_q) begin
            acc_d    = 1'b1;
            remain_d = remain_dec;
          end
        end
        pit_pkg::CmdStart: begin
          if (start_ok) begin
            acc_d     = 1'b1;
            session_d = '0;
            phase_d   = sph_q;
            length_d  = pit_pkg::minutes_to_seconds(start_min);
            remain_d  = pit_pkg::minutes_to_seconds(start_min);
            active_d  = 1'b1;
            running_d = 1'b1;
          end
        end
        pit_pkg::CmdPause: begin
          if (active_q && running_q) begin
            acc_d     = 1'b1;
            running_d = 1'b0;
          end
        end
        pit_pkg::CmdResume: begin
          if (active_q && !running_q) begin
            acc_d     = 1'b1;
            running_d = 1'b1;
          end
        end
        pit_pkg::CmdStop: begin
          if (active_q) begin
            acc_d     = 1'b1;
            active_d  = 1'b0;
            running_d = 1'b0;
            remain_d  = '0;
          end
        end
        pit_pkg::CmdSkip: begin
          if (active_q) acc_d = 1'b1;
        end
        default: begin
          acc_d = 1'b0;
        end
      endcase
      // A completed focus phase bumps the session count; the remainder
      // unit is primed with the new count either way.
      if (status_o.complete && status_o.focus) session_d = session_inc;
      div_d = session_inc;
      rem_d = '0;
    end

    if (cmd_i.mod_step) begin
      div_d = div_q << 1;
      rem_d = (rem_shift >= divisor) ? rem_shift - divisor : rem_shift;
    end

    if (cmd_i.enter) begin
      event_d   = (phase_q == pit_pkg::PhFocus) ? pit_pkg::EvFocus : pit_pkg::EvBreak;
      phase_d   = next_phase;
      length_d  = pit_pkg::minutes_to_seconds(next_cfg_min);
      remain_d  = pit_pkg::minutes_to_seconds(next_cfg_min);
      active_d  = 1'b1;
      running_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focus_min_q <= pit_pkg::FocusDefault;
      short_min_q <= pit_pkg::ShortDefault;
      long_min_q  <= pit_pkg::LongDefault;
      cycle_q     <= pit_pkg::CycleDefault;
      active_q    <= 1'b0;
      running_q   <= 1'b0;
      remain_q    <= '0;
      length_q    <= '0;
      session_q   <= '0;
      phase_q     <= pit_pkg::PhFocus;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          pit_pkg::CfgFocus: focus_min_q <= cfg_data_i;
          pit_pkg::CfgShort: short_min_q <= cfg_data_i;
          pit_pkg::CfgLong:  long_min_q  <= cfg_data_i;
          pit_pkg::CfgCycle: cycle_q     <= cfg_data_i[pit_pkg::CycleW-1:0];
          default: begin
            cycle_q <= cycle_q;
          end
        endcase
      end
      active_q  <= active_d;
      running_q <= running_d;
      remain_q  <= remain_d;
      length_q  <= length_d;
      session_q <= session_d;
      phase_q   <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    event_q <= event_d;
    div_q   <= div_d;
    rem_q   <= rem_d;
    if (cmd_i.latch_in) begin
      code_q <= cmd_code_i;
      sph_q  <= start_phase_i;
      smin_q <= start_minutes_i;
    end
    if (cmd_i.load_out) begin
      res_acc_q     <= acc_q;
      res_active_q  <= active_q;
      res_running_q <= running_q;
      res_remain_q  <= remain_q;
      res_length_q  <= length_q;
      res_session_q <= session_q;
      res_phase_q   <= phase_q;
      res_event_q   <= event_q;
    end
  end

  assign accepted_o          = res_acc_q;
  assign active_flag_o       = res_active_q;
  assign running_flag_o      = res_running_q;
  assign remaining_seconds_o = res_remain_q;
  assign phase_seconds_o     = res_length_q;
  assign sessions_done_o     = res_session_q;
  assign current_phase_o     = res_phase_q;
  assign phase_event_o       = res_event_q;

endmodule

// ----- hdl/phased_interval_timer_unit.sv -----
// Top level of the phased interval timer: joins the controller and the
// datapath to the command, result and configuration channels.
// Depends on pit_pkg, pit_if, pit_ctrl and pit_datapath.
//
//   Channel  Direction  Handshake     Carries
//   in_i     sink       valid/ready   cmd, start_phase, start_minutes
//   out_o    source     valid/ready   one result per request, the state after it
//   cfg_i    sink       valid/ready   register index and write data, always ready
//
// A request that ends no phase goes from evaluation straight to the result load; one that
// ends a break passes through phase entry first, and one that ends a focus phase runs the
// 16 single-bit steps of the session-count remainder before phase entry. The next request
// is accepted in the cycle after the result is loaded into the output register.
// Reset loads the configuration defaults and clears the timer state; no clearing pass.
// A stalled result waits in the output register while the next request is processed.
`timescale 1ns / 1ps

module phased_interval_timer_unit (
  input  logic clk_i,
  input  logic rst_ni,
  pit_in_if.sink    in_i,
  pit_out_if.source out_o,
  pit_cfg_if.sink   cfg_i
);

  pit_pkg::dp_cmd_t    dp_cmd;
  pit_pkg::dp_status_t dp_status;

  // Configuration writes land directly in the datapath registers, so the
  // write channel never stalls.
  assign cfg_i.ready = 1'b1;

  // The controller owns the handshakes and the sequencing of each request.
  pit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (dp_status),
    .cmd_o       (dp_cmd)
  );

  // The datapath holds the configuration and timer state and drives the result payload.
  pit_datapath u_datapath (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (dp_cmd),
    .status_o            (dp_status),
    .cfg_we_i            (cfg_i.valid),
    .cfg_index_i         (cfg_i.index),
    .cfg_data_i          (cfg_i.data),
    .cmd_code_i          (in_i.cmd),
    .start_phase_i       (in_i.start_phase),
    .start_minutes_i     (in_i.start_minutes),
    .accepted_o          (out_o.accepted),
    .active_flag_o       (out_o.active_flag),
    .running_flag_o      (out_o.running_flag),
    .remaining_seconds_o (out_o.remaining_seconds),
    .phase_seconds_o     (out_o.phase_seconds),
    .sessions_done_o     (out_o.sessions_done),
    .current_phase_o     (out_o.current_phase),
    .phase_event_o       (out_o.phase_event)
  );

endmodule
